### hw/rtl/spos_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Shuffled play order sequencer - shared definitions
// Field widths, register indexes, generator constants and the command and
// status words passed between the controller and the datapath.
// ----------------------------------------------------------------------------
package spos_pkg;

   localparam int MAX_ENTRIES_DEF = 64;

   localparam int ENTRY_COUNT_W = 7;
   localparam int SEED_W        = 32;
   localparam int FIRST_W       = 8;
   localparam int ENTRY_INDEX_W = 6;
   localparam int POSITION_W    = 6;

   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 7;

   localparam logic [CSR_INDEX_W-1:0] REG_ENTRY_COUNT   = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_RANDOM_ENABLE = 1'd1;

   localparam logic KIND_START   = 1'b0;
   localparam logic KIND_ADVANCE = 1'b1;

   localparam logic [SEED_W-1:0] RNG_ZERO_SUB = 32'h6D2B79F5;
   localparam int RNG_SHL_A = 13;
   localparam int RNG_SHR   = 17;
   localparam int RNG_SHL_B = 5;

   // remainder unit: bits retired per cycle
   localparam int MOD_BITS  = 4;
   localparam int MOD_STEPS = SEED_W / MOD_BITS;

   typedef struct packed {
      logic latch_req;
      logic pos_inc;
      logic rebuild;
      logic shuf_gen;
      logic shuf_next;
      logic swap_ij;
      logic swap_front;
      logic rd_swap;
      logic wr_a;
      logic wr_b;
      logic srch_rd;
      logic srch_next;
      logic out_rd;
      logic out_load;
   } spos_cmd_type;

   typedef struct packed {
      logic kind;
      logic wrap;
      logic shuffle_on;
      logic i_is_one;
      logic div_done;
      logic match;
      logic srch_last;
      logic rsp_full;
   } spos_stat_type;

   function automatic logic [SEED_W-1:0] rng_next(input logic [SEED_W-1:0] s);
      logic [SEED_W-1:0] v;
      v = (s == '0) ? RNG_ZERO_SUB : s;
      v ^= v << RNG_SHL_A;
      v ^= v >> RNG_SHR;
      v ^= v << RNG_SHL_B;
      return v;
   endfunction

endpackage
`default_nettype wire

### hw/rtl/spos_urem.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Shuffled play order sequencer - remainder unit
// Restoring remainder of a 32-bit value by a small divisor, a few dividend
// bits per cycle. Pulses done with the remainder held until the next start.
// ----------------------------------------------------------------------------
module spos_urem #(
   parameter int DIV_W = 7
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       start,
   input  wire logic [spos_pkg::SEED_W-1:0] dividend,
   input  wire logic [DIV_W-1:0]           divisor,
   output logic                            done,
   output logic [DIV_W-1:0]                remainder
);
   import spos_pkg::*;

   localparam int STEP_W = $clog2(MOD_STEPS);
   localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(MOD_STEPS - 1);

   logic [SEED_W-1:0] quot_ff, quot_in;
   logic [DIV_W-1:0]  rem_ff, rem_in, div_ff;
   logic [STEP_W-1:0] step_ff;
   logic              busy_ff, done_ff;

   always_comb begin : digit_step
      logic [DIV_W:0]    trial;
      logic [DIV_W-1:0]  r;
      logic [SEED_W-1:0] q;
      r     = rem_ff;
      q     = quot_ff;
      trial = '0;
      for (int b = 0; b < MOD_BITS; b++) begin
         trial = {r, q[SEED_W-1]};
         q     = {q[SEED_W-2:0], 1'b0};
         if (trial >= {1'b0, div_ff}) begin
            trial = trial - {1'b0, div_ff};
         end
         r = trial[DIV_W-1:0];
      end
      rem_in  = r;
      quot_in = q;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            step_ff <= '0;
         end else if (busy_ff) begin
            step_ff <= STEP_W'(step_ff + 1'b1);
            if (step_ff == LAST_STEP) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         quot_ff <= dividend;
         rem_ff  <= '0;
         div_ff  <= divisor;
      end else if (busy_ff) begin
         quot_ff <= quot_in;
         rem_ff  <= rem_in;
      end
   end

   assign done      = done_ff;
   assign remainder = rem_ff;

endmodule
`default_nettype wire

### hw/rtl/spos_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Shuffled play order sequencer - datapath
// Configuration registers, play order memory with per-entry valid bits,
// generator state, shuffle and search counters, and the response register.
// ----------------------------------------------------------------------------
module spos_datapath #(
   parameter int MAX_ENTRIES = spos_pkg::MAX_ENTRIES_DEF
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              csr_write_enable,
   input  wire logic [spos_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  wire logic [spos_pkg::CSR_DATA_W-1:0]   csr_write_data,
   input  wire logic                              req_kind,
   input  wire logic [spos_pkg::SEED_W-1:0]       req_seed,
   input  wire logic [spos_pkg::FIRST_W-1:0]      req_lead_entry,
   input  wire logic                              rsp_ready,
   output logic                                   rsp_valid,
   output logic [spos_pkg::ENTRY_INDEX_W-1:0]     rsp_entry_index,
   output logic [spos_pkg::POSITION_W-1:0]        rsp_position,
   output logic                                   rsp_rebuilt,
   input  wire spos_pkg::spos_cmd_type            cmd,
   output spos_pkg::spos_stat_type                stat
);
   import spos_pkg::*;

   localparam int IDX_W = $clog2(MAX_ENTRIES);
   localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
   localparam int CMP_W = (CNT_W > ENTRY_COUNT_W) ? CNT_W : ENTRY_COUNT_W;
   localparam int FST_W = (CNT_W > FIRST_W) ? CNT_W : FIRST_W;
   localparam int EIX_W = IDX_W + ENTRY_INDEX_W;
   localparam int EPS_W = IDX_W + POSITION_W;
   localparam logic [CMP_W-1:0] MAX_CMP = CMP_W'(MAX_ENTRIES);

   // configuration
   logic [ENTRY_COUNT_W-1:0] entry_count_ff;
   logic                     random_enable_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_count_ff   <= ENTRY_COUNT_W'(1);
         random_enable_ff <= 1'b0;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            REG_ENTRY_COUNT:   entry_count_ff   <= csr_write_data[ENTRY_COUNT_W-1:0];
            REG_RANDOM_ENABLE: random_enable_ff <= csr_write_data[0];
         endcase
      end
   end

   logic [CMP_W-1:0] cnt_sat;
   logic [CNT_W-1:0] count;

   always_comb begin
      cnt_sat = CMP_W'(entry_count_ff);
      if (cnt_sat == '0) begin
         cnt_sat = CMP_W'(1);
      end
      if (cnt_sat > MAX_CMP) begin
         cnt_sat = MAX_CMP;
      end
      count = cnt_sat[CNT_W-1:0];
   end

   // item and sequencing registers
   logic                 kind_ff;
   logic [SEED_W-1:0]    seed_ff;
   logic [FIRST_W-1:0]   first_ff;
   logic                 built_ff;
   logic [IDX_W-1:0]     pos_ff;
   logic [IDX_W-1:0]     i_ff;
   logic [IDX_W-1:0]     k_ff;
   logic [IDX_W-1:0]     a_ff, b_ff;
   logic [SEED_W-1:0]    rng_ff, rng_in;
   logic [MAX_ENTRIES-1:0] vld_ff;
   logic [MAX_ENTRIES-1:0] low_mask;

   logic [CNT_W-1:0]     divisor;
   logic [CNT_W-1:0]     rem;
   logic                 div_done;
   logic [IDX_W-1:0]     target;
   logic [IDX_W-1:0]     val_a, val_b;

   assign rng_in  = rng_next(rng_ff);
   assign divisor = CNT_W'(CNT_W'(i_ff) + CNT_W'(1));

   always_comb begin
      for (int e = 0; e < MAX_ENTRIES; e++) begin
         low_mask[e] = (CNT_W'(e) < count);
      end
   end

   always_comb begin
      if (FST_W'(first_ff) >= FST_W'(count)) begin
         target = '0;
      end else begin
         target = first_ff[IDX_W-1:0];
      end
   end

   spos_urem #(
      .DIV_W(CNT_W)
   ) u_urem (
      .clock     (clock),
      .reset     (reset),
      .start     (cmd.shuf_gen),
      .dividend  (rng_in),
      .divisor   (divisor),
      .done      (div_done),
      .remainder (rem)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff   <= '0;
         rng_ff   <= SEED_W'(1);
         vld_ff   <= '0;
         built_ff <= 1'b0;
      end else begin
         if (cmd.latch_req) begin
            built_ff <= 1'b0;
         end
         if (cmd.pos_inc) begin
            pos_ff <= IDX_W'(pos_ff + 1'b1);
         end
         if (cmd.rebuild) begin
            pos_ff   <= '0;
            rng_ff   <= (seed_ff == '0) ? SEED_W'(1) : seed_ff;
            vld_ff   <= vld_ff & ~low_mask;
            built_ff <= 1'b1;
         end
         if (cmd.shuf_gen) begin
            rng_ff <= rng_in;
         end
         if (cmd.wr_a) begin
            vld_ff[a_ff] <= 1'b1;
         end
         if (cmd.wr_b) begin
            vld_ff[b_ff] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.latch_req) begin
         kind_ff  <= req_kind;
         seed_ff  <= req_seed;
         first_ff <= req_lead_entry;
      end
      if (cmd.rebuild) begin
         i_ff <= IDX_W'(count - CNT_W'(1));
         k_ff <= '0;
      end
      if (cmd.shuf_next) begin
         i_ff <= IDX_W'(i_ff - 1'b1);
      end
      if (cmd.srch_next) begin
         k_ff <= IDX_W'(k_ff + 1'b1);
      end
      if (cmd.swap_ij) begin
         a_ff <= i_ff;
         b_ff <= rem[IDX_W-1:0];
      end
      if (cmd.swap_front) begin
         a_ff <= '0;
         b_ff <= k_ff;
      end
   end

   // play order memory
   logic [IDX_W-1:0] mem [MAX_ENTRIES];
   logic [IDX_W-1:0] rd_a_addr;
   logic             rd_a_en;
   logic [IDX_W-1:0] rd_a_data_ff, rd_a_addr_ff, rd_b_data_ff, rd_b_addr_ff;
   logic             rd_a_vld_ff, rd_b_vld_ff;
   logic             wr_en;
   logic [IDX_W-1:0] wr_addr, wr_data;

   always_comb begin
      priority if (cmd.out_rd) begin
         rd_a_addr = pos_ff;
      end else if (cmd.srch_rd) begin
         rd_a_addr = k_ff;
      end else begin
         rd_a_addr = a_ff;
      end
   end

   assign rd_a_en = cmd.out_rd | cmd.srch_rd | cmd.rd_swap;
   assign wr_en   = cmd.wr_a | cmd.wr_b;
   assign wr_addr = cmd.wr_a ? a_ff : b_ff;
   assign wr_data = cmd.wr_a ? val_b : val_a;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_a_en) begin
         rd_a_data_ff <= mem[rd_a_addr];
         rd_a_vld_ff  <= vld_ff[rd_a_addr];
         rd_a_addr_ff <= rd_a_addr;
      end
      if (cmd.rd_swap) begin
         rd_b_data_ff <= mem[b_ff];
         rd_b_vld_ff  <= vld_ff[b_ff];
         rd_b_addr_ff <= b_ff;
      end
   end

   // an entry with its valid bit clear reads as its own index; a rebuild clears the bits below the count only
   assign val_a = rd_a_vld_ff ? rd_a_data_ff : rd_a_addr_ff;
   assign val_b = rd_b_vld_ff ? rd_b_data_ff : rd_b_addr_ff;

   // response register
   logic                     rsp_valid_ff;
   logic [ENTRY_INDEX_W-1:0] rsp_entry_ff;
   logic [POSITION_W-1:0]    rsp_pos_ff;
   logic                     rsp_rebuilt_ff;
   logic [EIX_W-1:0]         ent_ext;
   logic [EPS_W-1:0]         pos_ext;

   assign ent_ext = EIX_W'(val_a);
   assign pos_ext = EPS_W'(pos_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         rsp_entry_ff   <= ent_ext[ENTRY_INDEX_W-1:0];
         rsp_pos_ff     <= pos_ext[POSITION_W-1:0];
         rsp_rebuilt_ff <= built_ff;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_entry_index = rsp_entry_ff;
   assign rsp_position    = rsp_pos_ff;
   assign rsp_rebuilt     = rsp_rebuilt_ff;

   // status
   always_comb begin
      stat.kind       = kind_ff;
      stat.wrap       = CNT_W'(CNT_W'(pos_ff) + CNT_W'(1)) >= count;
      stat.shuffle_on = random_enable_ff && (count >= CNT_W'(2));
      stat.i_is_one   = (i_ff == IDX_W'(1));
      stat.div_done   = div_done;
      stat.match      = (val_a == target);
      stat.srch_last  = CNT_W'(CNT_W'(k_ff) + CNT_W'(1)) >= count;
      stat.rsp_full   = rsp_valid_ff & ~rsp_ready;
   end

endmodule
`default_nettype wire

### hw/rtl/spos_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Shuffled play order sequencer - controller
// Sequences one word at a time: dispatch, rebuild, shuffle steps with swaps,
// front search and swap, response load.
// ----------------------------------------------------------------------------
module spos_ctrl (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_valid,
   output logic                         req_ready,
   output spos_pkg::spos_cmd_type       cmd,
   input  wire spos_pkg::spos_stat_type stat
);
   import spos_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DISPATCH,
      ST_REBUILD,
      ST_SH_GEN,
      ST_SH_DIV,
      ST_SW_RD,
      ST_SW_WA,
      ST_SW_WB,
      ST_SR_RD,
      ST_SR_CMP,
      ST_OUT_RD,
      ST_OUT_LD
   } state_type;

   state_type state_ff, state_in;
   logic      ready_ff, ready_in;
   logic      front_ff, front_in;

   always_comb begin
      state_in = state_ff;
      front_in = front_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid && ready_ff) begin
               cmd.latch_req = 1'b1;
               state_in      = ST_DISPATCH;
            end
         end
         ST_DISPATCH: begin
            if (stat.kind == KIND_ADVANCE && !stat.wrap) begin
               cmd.pos_inc = 1'b1;
               state_in    = ST_OUT_RD;
            end else begin
               state_in = ST_REBUILD;
            end
         end
         ST_REBUILD: begin
            cmd.rebuild = 1'b1;
            front_in    = 1'b0;
            priority if (stat.shuffle_on) begin
               state_in = ST_SH_GEN;
            end else if (stat.kind == KIND_START) begin
               state_in = ST_SR_RD;
            end else begin
               state_in = ST_OUT_RD;
            end
         end
         ST_SH_GEN: begin
            cmd.shuf_gen = 1'b1;
            state_in     = ST_SH_DIV;
         end
         ST_SH_DIV: begin
            if (stat.div_done) begin
               cmd.swap_ij = 1'b1;
               state_in    = ST_SW_RD;
            end
         end
         ST_SW_RD: begin
            cmd.rd_swap = 1'b1;
            state_in    = ST_SW_WA;
         end
         ST_SW_WA: begin
            cmd.wr_a = 1'b1;
            state_in = ST_SW_WB;
         end
         ST_SW_WB: begin
            cmd.wr_b = 1'b1;
            if (front_ff) begin
               state_in = ST_OUT_RD;
            end else begin
               cmd.shuf_next = 1'b1;
               priority if (!stat.i_is_one) begin
                  state_in = ST_SH_GEN;
               end else if (stat.kind == KIND_START) begin
                  state_in = ST_SR_RD;
               end else begin
                  state_in = ST_OUT_RD;
               end
            end
         end
         ST_SR_RD: begin
            cmd.srch_rd = 1'b1;
            state_in    = ST_SR_CMP;
         end
         ST_SR_CMP: begin
            priority if (stat.match) begin
               cmd.swap_front = 1'b1;
               front_in       = 1'b1;
               state_in       = ST_SW_RD;
            end else if (stat.srch_last) begin
               state_in = ST_OUT_RD;
            end else begin
               cmd.srch_next = 1'b1;
               state_in      = ST_SR_RD;
            end
         end
         ST_OUT_RD: begin
            cmd.out_rd = 1'b1;
            state_in   = ST_OUT_LD;
         end
         ST_OUT_LD: begin
            if (!stat.rsp_full) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      ready_in = (state_in == ST_IDLE);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         ready_ff <= 1'b1;
         front_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         ready_ff <= ready_in;
         front_ff <= front_in;
      end
   end

   assign req_ready = ready_ff;

endmodule
`default_nettype wire

### hw/rtl/shuffled_play_order_sequencer_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Shuffled play order sequencer
// Keeps a play order, a position in it and an xorshift32 state. Start words
// rebuild the order, shuffle it when enabled and bring the requested entry
// to the front; advance words step the position or wrap and rebuild.
// ----------------------------------------------------------------------------
//   channel | direction | handshake              | payload
//   req     | in        | req_valid / req_ready  | kind, seed, lead_entry
//   rsp     | out       | rsp_valid / rsp_ready  | entry_index, position, rebuilt
//   csr     | in        | csr_write_enable       | csr_index, csr_write_data
//
// Advance without wrap: dispatch steps the position, then the order is read and the response loaded.
// Rebuild with shuffling: each step makes an xorshift update, takes the
// remainder, and swaps (read, write a, write b) through the single memory
// write port; without shuffling the order is only reset. A start adds the
// front search and swap.
// Reset: synchronous; the play order reads as identity at once (valid bits).
// A new word is taken while the previous response waits; the next load holds.
// ----------------------------------------------------------------------------
module shuffled_play_order_sequencer_unit #(
   parameter int MAX_ENTRIES = spos_pkg::MAX_ENTRIES_DEF
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             csr_write_enable,
   input  wire logic [spos_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire logic [spos_pkg::CSR_DATA_W-1:0]  csr_write_data,
   input  wire logic                             req_valid,
   output logic                                  req_ready,
   input  wire logic                             req_kind,
   input  wire logic [spos_pkg::SEED_W-1:0]      req_seed,
   input  wire logic [spos_pkg::FIRST_W-1:0]     req_lead_entry,
   output logic                                  rsp_valid,
   input  wire logic                             rsp_ready,
   output logic [spos_pkg::ENTRY_INDEX_W-1:0]    rsp_entry_index,
   output logic [spos_pkg::POSITION_W-1:0]       rsp_position,
   output logic                                  rsp_rebuilt
);
   import spos_pkg::*;

   spos_cmd_type  cmd;
   spos_stat_type stat;

   spos_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .cmd       (cmd),
      .stat      (stat)
   );

   spos_datapath #(
      .MAX_ENTRIES(MAX_ENTRIES)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .req_kind         (req_kind),
      .req_seed         (req_seed),
      .req_lead_entry   (req_lead_entry),
      .rsp_ready        (rsp_ready),
      .rsp_valid        (rsp_valid),
      .rsp_entry_index  (rsp_entry_index),
      .rsp_position     (rsp_position),
      .rsp_rebuilt      (rsp_rebuilt),
      .cmd              (cmd),
      .stat             (stat)
   );

endmodule
`default_nettype wire

### hw/rtl/spos_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Shuffled play order sequencer - port checker
// Watches the top level ports: response hold, rebuild position, busy after
// accept and quiet response after reset.
// ----------------------------------------------------------------------------
module spos_checker (
   input wire logic                               clock,
   input wire logic                               reset,
   input wire logic                               req_valid,
   input wire logic                               req_ready,
   input wire logic                               rsp_valid,
   input wire logic                               rsp_ready,
   input wire logic [spos_pkg::ENTRY_INDEX_W-1:0] rsp_entry_index,
   input wire logic [spos_pkg::POSITION_W-1:0]    rsp_position,
   input wire logic                               rsp_rebuilt
);

   // hold a stalled response word
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_entry_index)
         && $stable(rsp_position) && $stable(rsp_rebuilt))
      else $error("response word changed while stalled");

   // a rebuilt order always restarts at position zero
   a_rebuilt_pos: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_rebuilt |-> rsp_position == '0)
      else $error("rebuilt response not at position zero");

   // drop ready once a word is taken
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("ready held after accept");

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

endmodule

bind shuffled_play_order_sequencer_unit spos_checker u_spos_checker (.*);
`default_nettype wire

### verif/shuffled_play_order_sequencer_unit_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Shuffled play order sequencer - testbench
// Sends start and advance words through a valid/ready driver. A local model
// of the shuffle, the xorshift generator and the play position predicts each
// response, and every response field is checked in arrival order. The
// registers change between phases while the unit is idle. Phases cover the
// count extremes and both shuffle settings, with and without stalls.
// ----------------------------------------------------------------------------
module shuffled_play_order_sequencer_unit_tb;
   import spos_pkg::*;

   localparam int          MAX_PLAY      = MAX_ENTRIES_DEF;
   localparam logic [31:0] GEN_ZERO_FILL = 32'h6D2B79F5;
   localparam int          RANDOM_WORDS  = 1100;
   localparam int          SETTLE_CYCLES = 8;
   localparam int          END_CYCLES    = 40;
   localparam longint      CYCLE_LIMIT   = 6_000_000;

   typedef struct {
      logic                kind;
      logic [SEED_W-1:0]   seed;
      logic [FIRST_W-1:0]  lead_entry;
   } play_word_type;

   typedef struct {
      logic [ENTRY_INDEX_W-1:0] entry_index;
      logic [POSITION_W-1:0]    position;
      logic                     rebuilt;
   } play_rsp_type;

   logic                     clock            = 1'b0;
   logic                     reset            = 1'b1;
   logic                     csr_write_enable = 1'b0;
   logic [CSR_INDEX_W-1:0]   csr_index        = REG_ENTRY_COUNT;
   logic [CSR_DATA_W-1:0]    csr_write_data   = '0;
   logic                     req_valid        = 1'b0;
   logic                     req_ready;
   logic                     req_kind         = KIND_START;
   logic [SEED_W-1:0]        req_seed         = '0;
   logic [FIRST_W-1:0]       req_lead_entry   = '0;
   logic                     rsp_valid;
   logic                     rsp_ready        = 1'b0;
   logic [ENTRY_INDEX_W-1:0] rsp_entry_index;
   logic [POSITION_W-1:0]    rsp_position;
   logic                     rsp_rebuilt;

   play_word_type pending_words[$];
   play_rsp_type  expected_plays[$];
   play_word_type word_on_bus;
   int unsigned words_in_flight = 0;
   int unsigned mismatches      = 0;
   int unsigned req_gap_max     = 0;
   int unsigned rsp_gap_max     = 0;
   int unsigned req_wait        = 0;
   int unsigned rsp_wait        = 0;
   longint      cycles          = 0;

   logic [ENTRY_INDEX_W-1:0] order_copy [MAX_PLAY];
   int unsigned              pos_copy;
   logic [SEED_W-1:0]        gen_copy;
   logic [ENTRY_COUNT_W-1:0] count_reg;
   logic                     shuffle_reg;

   shuffled_play_order_sequencer_unit uut (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_kind         (req_kind),
      .req_seed         (req_seed),
      .req_lead_entry   (req_lead_entry),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_entry_index  (rsp_entry_index),
      .rsp_position     (rsp_position),
      .rsp_rebuilt      (rsp_rebuilt)
   );

   always #10 clock = ~clock;

   function automatic int unsigned live_count();
      if (count_reg == 0) return 1;
      if (count_reg > MAX_PLAY) return MAX_PLAY;
      return 32'(count_reg);
   endfunction

   function automatic void rebuild_order(input logic [SEED_W-1:0] seed, input int unsigned n);
      int unsigned              i;
      int unsigned              j;
      logic [ENTRY_INDEX_W-1:0] t;
      for (i = 0; i < n; i++) order_copy[i] = i[ENTRY_INDEX_W-1:0];
      gen_copy = (seed == '0) ? 32'd1 : seed;
      if (shuffle_reg && n >= 2) begin
         for (i = n - 1; i > 0; i--) begin
            if (gen_copy == '0) gen_copy = GEN_ZERO_FILL;
            gen_copy = gen_copy ^ (gen_copy << 13);
            gen_copy = gen_copy ^ (gen_copy >> 17);
            gen_copy = gen_copy ^ (gen_copy << 5);
            j = gen_copy % (i + 1);
            t = order_copy[i];
            order_copy[i] = order_copy[j];
            order_copy[j] = t;
         end
      end
   endfunction

   function automatic void predict_play(input play_word_type w);
      int unsigned              n;
      int unsigned              first;
      int unsigned              k;
      logic [ENTRY_INDEX_W-1:0] t;
      logic                     found;
      logic                     built;
      play_rsp_type             r;
      n = live_count();
      built = 1'b0;
      if (w.kind == KIND_START) begin
         rebuild_order(w.seed, n);
         first = (w.lead_entry >= n) ? 0 : 32'(w.lead_entry);
         found = 1'b0;
         for (k = 0; k < n; k++) begin
            if (!found && order_copy[k] == first) begin
               t = order_copy[0];
               order_copy[0] = order_copy[k];
               order_copy[k] = t;
               found = 1'b1;
            end
         end
         pos_copy = 0;
         built = 1'b1;
      end else if (pos_copy + 1 < n) begin
         pos_copy++;
      end else begin
         pos_copy = 0;
         rebuild_order(w.seed, n);
         built = 1'b1;
      end
      r.entry_index = order_copy[pos_copy];
      r.position    = pos_copy[POSITION_W-1:0];
      r.rebuilt     = built;
      expected_plays.push_back(r);
   endfunction

   // driver: hold the word until taken, then advance or idle
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         req_wait  <= 0;
      end else if (!req_valid || req_ready) begin
         if (req_valid) predict_play(word_on_bus);
         if (req_wait != 0) begin
            req_valid <= 1'b0;
            req_wait  <= req_wait - 1;
         end else if (pending_words.size() != 0) begin
            word_on_bus = pending_words.pop_front();
            req_valid       <= 1'b1;
            req_kind        <= word_on_bus.kind;
            req_seed        <= word_on_bus.seed;
            req_lead_entry  <= word_on_bus.lead_entry;
            req_wait        <= $urandom_range(0, req_gap_max);
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      play_rsp_type e;
      int unsigned  stall;
      if (reset) begin
         rsp_ready <= 1'b0;
         rsp_wait  <= 0;
      end else if (rsp_valid && rsp_ready) begin
         if (expected_plays.size() == 0) begin
            $error("response with no word outstanding: entry_index %0d position %0d",
                   rsp_entry_index, rsp_position);
            mismatches++;
         end else begin
            e = expected_plays.pop_front();
            words_in_flight--;
            if (rsp_entry_index !== e.entry_index) begin
               $error("entry_index mismatch: expected %0d, got %0d",
                      e.entry_index, rsp_entry_index);
               mismatches++;
            end
            if (rsp_position !== e.position) begin
               $error("position mismatch: expected %0d, got %0d", e.position, rsp_position);
               mismatches++;
            end
            if (rsp_rebuilt !== e.rebuilt) begin
               $error("rebuilt mismatch: expected %0d, got %0d", e.rebuilt, rsp_rebuilt);
               mismatches++;
            end
         end
         stall = $urandom_range(0, rsp_gap_max);
         rsp_wait  <= stall;
         rsp_ready <= (stall == 0);
      end else if (rsp_wait != 0) begin
         rsp_wait  <= rsp_wait - 1;
         rsp_ready <= (rsp_wait == 1);
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   task automatic push_word(input logic kind, input logic [SEED_W-1:0] seed,
                            input logic [FIRST_W-1:0] lead_entry);
      play_word_type w;
      w.kind       = kind;
      w.seed       = seed;
      w.lead_entry = lead_entry;
      words_in_flight++;
      pending_words.push_back(w);
   endtask

   task automatic write_reg(input logic [CSR_INDEX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] value);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      if (idx == REG_ENTRY_COUNT) count_reg = value;
      else shuffle_reg = value[0];
   endtask

   task automatic wait_idle();
      while (words_in_flight != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   initial begin
      int unsigned        k;
      int unsigned        n;
      int unsigned        pick;
      int unsigned        phase_len;
      int unsigned        run_left;
      int unsigned        queued;
      logic [SEED_W-1:0]  seed;
      logic [CSR_DATA_W-1:0] csr_val;

      for (k = 0; k < MAX_PLAY; k++) order_copy[k] = k[ENTRY_INDEX_W-1:0];
      pos_copy    = 0;
      gen_copy    = 32'd1;
      count_reg   = 7'd1;
      shuffle_reg = 1'b0;

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // advance straight after reset, single entry
      push_word(KIND_ADVANCE, 32'h0000_0000, 8'h00);
      push_word(KIND_ADVANCE, 32'hFFFF_FFFF, 8'hFF);
      wait_idle();
      write_reg(REG_ENTRY_COUNT, 7'd8);
      push_word(KIND_ADVANCE, 32'h1234_5678, 8'd3);
      push_word(KIND_ADVANCE, 32'h8765_4321, 8'd0);
      push_word(KIND_START, 32'hDEAD_BEEF, 8'd5);
      push_word(KIND_START, 32'h0000_0000, 8'd255);
      push_word(KIND_ADVANCE, 32'hCAFE_F00D, 8'd1);
      wait_idle();
      write_reg(REG_RANDOM_ENABLE, 7'd1);
      write_reg(REG_ENTRY_COUNT, 7'd64);
      push_word(KIND_START, 32'h0000_0000, 8'd63);
      push_word(KIND_START, 32'hFFFF_FFFF, 8'd64);
      push_word(KIND_ADVANCE, 32'h0F0F_0F0F, 8'd0);
      wait_idle();
      write_reg(REG_ENTRY_COUNT, 7'd0);
      push_word(KIND_START, 32'h0000_0005, 8'd7);
      push_word(KIND_ADVANCE, 32'h0000_0000, 8'd0);
      wait_idle();
      write_reg(REG_ENTRY_COUNT, 7'd127);
      push_word(KIND_START, 32'h8000_0000, 8'd200);
      push_word(KIND_ADVANCE, 32'h7FFF_FFFF, 8'd128);
      wait_idle();
      write_reg(REG_ENTRY_COUNT, 7'd2);
      push_word(KIND_START, 32'h0000_0003, 8'd1);
      push_word(KIND_ADVANCE, 32'hAAAA_AAAA, 8'd0);
      push_word(KIND_ADVANCE, 32'h5555_5555, 8'd0);
      wait_idle();
      write_reg(REG_ENTRY_COUNT, 7'd4);
      push_word(KIND_START, 32'h55AA_55AA, 8'd2);
      for (k = 0; k < 3; k++) push_word(KIND_ADVANCE, $urandom(), 8'd0);
      wait_idle();
      // grow and shrink the count under a running order
      write_reg(REG_ENTRY_COUNT, 7'd10);
      push_word(KIND_ADVANCE, 32'h0000_1111, 8'd0);
      wait_idle();
      write_reg(REG_ENTRY_COUNT, 7'd3);
      push_word(KIND_ADVANCE, 32'h0000_2222, 8'd0);

      queued   = 0;
      run_left = 0;
      while (queued < RANDOM_WORDS) begin
         wait_idle();
         pick = $urandom_range(0, 99);
         if (pick < 6) pick = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(65, 127);
         else if (pick < 14) pick = 64;
         else if (pick < 30) pick = $urandom_range(13, 63);
         else pick = $urandom_range(1, 12);
         write_reg(REG_ENTRY_COUNT, pick[CSR_DATA_W-1:0]);
         csr_val = 7'($urandom_range(0, 127));
         csr_val[0] = ($urandom_range(0, 3) != 0);
         write_reg(REG_RANDOM_ENABLE, csr_val);
         req_gap_max = ($urandom_range(0, 2) == 0) ? 0 : 19;
         rsp_gap_max = ($urandom_range(0, 2) == 0) ? 0 : 19;
         n = live_count();
         if ($urandom_range(0, 1) == 0) run_left = 0;
         phase_len = $urandom_range(20, 70);
         for (k = 0; k < phase_len; k++) begin
            pick = $urandom_range(0, 19);
            seed = (pick == 0) ? 32'h0000_0000 :
                   (pick == 1) ? 32'hFFFF_FFFF : $urandom();
            if ($urandom_range(0, 9) == 0) begin
               push_word(1'($urandom_range(0, 1)), seed, 8'($urandom_range(0, 255)));
            end else if (run_left == 0) begin
               push_word(KIND_START, seed, ($urandom_range(0, 7) == 0) ?
                         8'($urandom_range(0, 255)) : 8'($urandom_range(0, n - 1)));
               run_left = $urandom_range(1, 2 * n + 2);
            end else begin
               push_word(KIND_ADVANCE, seed, 8'($urandom_range(0, 255)));
               run_left--;
            end
         end
         queued += phase_len;
      end

      wait_idle();
      repeat (END_CYCLES) @(posedge clock);
      if (mismatches == 0 && expected_plays.size() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

### filelist.f
hw/rtl/spos_pkg.sv
hw/rtl/spos_urem.sv
hw/rtl/spos_datapath.sv
hw/rtl/spos_ctrl.sv
hw/rtl/shuffled_play_order_sequencer_unit.sv
hw/rtl/spos_checker.sv
verif/shuffled_play_order_sequencer_unit_tb.sv
